// ===== hw/rtl/wsc_pkg.sv =====
// Shared types, widths and constants of the windowed-sinc coefficient block.
`timescale 1ns / 1ps
package wsc_pkg;

  // Field and register widths
  localparam int unsigned KSIZE_W    = 7;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned TAP_W      = 6;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MAX_TAPS_DEF = 64;

  // Register reset values
  localparam logic [KSIZE_W-1:0] KSIZE_RST = 7'd8;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 16'd32768;

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_SIZE = 2'd0,
    CFG_HANN_ALPHA  = 2'd1,
    CFG_FRACTION    = 2'd2
  } cfg_reg_e;

  // Q30 arithmetic
  localparam int unsigned Q30_W = 31;
  localparam logic [Q30_W-1:0] ONE_Q30 = 31'd1073741824;
  localparam logic [Q30_W-1:0] SIN_C1  = 31'd1686629713;
  localparam logic [Q30_W-1:0] SIN_C3  = 31'd693598669;
  localparam logic [Q30_W-1:0] SIN_C5  = 31'd85569306;
  localparam logic [Q30_W-1:0] SIN_C7  = 31'd5026995;
  localparam logic [Q30_W-1:0] SIN_C9  = 31'd172272;
  localparam logic [Q30_W-1:0] PI_Q29  = 31'd1686629713;

  // Internal datapath widths
  localparam int unsigned AX_W     = 23;  // |x| in Q16
  localparam int unsigned NN_W     = 6;   // window position
  localparam int unsigned D_W      = 7;   // N - 1
  localparam int unsigned DEN_A_W  = 29;  // (pi * |x|) >> 25
  localparam int unsigned NUM_A_W  = 51;  // sin << 20
  localparam int unsigned QA_W     = 32;  // sinc quotient bits
  localparam int unsigned NUM_B_W  = 23;  // (nn << 17) + d
  localparam int unsigned DEN_B_W  = 8;   // 2 * d
  localparam int unsigned QB_W     = 17;  // window phase quotient bits
  localparam int unsigned SIN_F_W  = 17;  // sine argument, Q16 in [0, 1]

  // Pipeline timing, in cycles after the head of the queue is taken
  localparam int unsigned SIN_LAT = 6;
  localparam int unsigned MAG_AT  = SIN_LAT + QA_W;
  localparam int unsigned H_AT    = QB_W + SIN_LAT + 1;
  localparam int unsigned WIN_AT  = H_AT + 1;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic               in_range;
    logic               neg;
    logic               xzero;
    logic               centre;
    logic [AX_W-1:0]    ax;
    logic [NN_W-1:0]    nn;
    logic [D_W-1:0]     d;
    logic [ALPHA_W-1:0] alpha;
  } wsc_item_t;

  // Horner coefficients of the sine polynomial, innermost step first
  function automatic logic [Q30_W-1:0] horner_coef(input logic [1:0] k);
    logic [Q30_W-1:0] c;
    unique case (k)
      2'd0: c = SIN_C7;
      2'd1: c = SIN_C5;
      2'd2: c = SIN_C3;
      2'd3: c = SIN_C1;
      default: c = SIN_C1;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/wsc_queue.sv =====
// Short item queue between the front and the back of the coefficient block.
`timescale 1ns / 1ps
module wsc_queue import wsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  wsc_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output wsc_item_t item_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  wsc_item_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  // Advance pointers with wrap
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PW+1)'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

// ===== hw/rtl/wsc_front.sv =====
// Front end: configuration registers and classification of each tap index.
`timescale 1ns / 1ps
module wsc_front import wsc_pkg::*; #(
  parameter int unsigned MaxTaps = MAX_TAPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [TAP_W-1:0]      tap_index_i,
  output wsc_item_t             item_o
);

  logic [KSIZE_W-1:0] size_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [FRAC_W-1:0]  frac_q;

  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indices are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= KSIZE_RST;
      alpha_q <= '0;
      frac_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_KERNEL_SIZE: size_q  <= cfg_data_i[KSIZE_W-1:0];
        CFG_HANN_ALPHA:  alpha_q <= cfg_data_i[ALPHA_W-1:0];
        CFG_FRACTION:    frac_q  <= cfg_data_i[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  logic [KSIZE_W-1:0] n;
  logic [KSIZE_W-1:0] half;
  logic [KSIZE_W-1:0] tap_ext;
  logic [KSIZE_W-1:0] ip1;
  logic [23:0]        a24, b24, x;
  logic [23:0]        xabs;
  logic [KSIZE_W-1:0] mirror;

  // Classify the tap: range, sign of sinc, window position
  always_comb begin
    n       = (int'(size_q) > int'(MaxTaps)) ? KSIZE_W'(MaxTaps) : size_q;
    half    = n >> 1;
    tap_ext = {1'b0, tap_index_i};
    ip1     = tap_ext + KSIZE_W'(1);
    a24     = {1'b0, ip1, 16'b0};
    b24     = {2'b0, n, 15'b0} + {8'b0, frac_q};
    x       = a24 - b24;
    xabs    = x[23] ? (24'd0 - x) : x;
    mirror  = n - KSIZE_W'(1) - tap_ext;

    item_o.in_range = (tap_ext < n);
    item_o.ax       = xabs[AX_W-1:0];
    item_o.xzero    = (x == '0);
    item_o.neg      = xabs[16];
    item_o.centre   = n[0] && (tap_ext == half);
    item_o.nn       = (tap_ext < half) ? tap_index_i : mirror[NN_W-1:0];
    item_o.d        = n - KSIZE_W'(1);
    item_o.alpha    = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  end

endmodule

// ===== hw/rtl/wsc_sin.sv =====
// Pipelined sin(pi f) by an odd polynomial, one argument per cycle while en_i is high.
`timescale 1ns / 1ps
module wsc_sin import wsc_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SIN_F_W-1:0] f_i,
  output logic [Q30_W-1:0]   s_o
);

  logic [SIN_F_W-1:0] fc, fm, t;
  logic [Q30_W-1:0]   t30_d;
  logic [61:0]        sq;

  logic [Q30_W-1:0] t30_q [5];
  logic [Q30_W-1:0] t2_q  [4];
  logic [Q30_W-1:0] p_q   [4];
  logic [Q30_W-1:0] p_d   [4];
  logic [Q30_W-1:0] s_q;
  logic [61:0]      prod  [4];
  logic [31:0]      diff  [4];
  logic [61:0]      fin;
  logic [Q30_W-1:0] s_d;

  // Fold the argument onto the rising quarter wave
  always_comb begin
    fc    = (f_i > 17'd65536) ? 17'd65536 : f_i;
    fm    = 17'd65536 - fc;
    t     = (fc <= 17'd32768) ? {fc[15:0], 1'b0} : {fm[15:0], 1'b0};
    t30_d = {t, 14'b0};
    sq    = 62'(t30_d) * 62'(t30_d);
  end

  // Horner steps, each on its own stage
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod[k] = (k == 0) ? 62'(SIN_C9) * 62'(t2_q[k]) : 62'(p_q[(k == 0) ? 0 : k-1]) * 62'(t2_q[k]);
      diff[k] = {1'b0, horner_coef(2'(k))} - prod[k][61:30];
      p_d[k]  = diff[k][Q30_W-1:0];
    end
    fin = 62'(p_q[3]) * 62'(t30_q[4]);
    s_d = (fin[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : fin[Q30_W-1+30:30];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t30_q[0] <= t30_d;
      t2_q[0]  <= sq[60:30];
      for (int k = 1; k < 5; k++) begin
        t30_q[k] <= t30_q[k-1];
      end
      for (int k = 1; k < 4; k++) begin
        t2_q[k] <= t2_q[k-1];
      end
      for (int k = 0; k < 4; k++) begin
        p_q[k] <= p_d[k];
      end
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

// ===== hw/rtl/wsc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
`timescale 1ns / 1ps
module wsc_div #(
  parameter int unsigned NW = 51,
  parameter int unsigned DW = 29,
  parameter int unsigned QW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  logic [HW-1:0] hi;
  logic [CW-1:0] hi_ext;
  logic          sat_d;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [DW-1:0] den_q [QW];
  logic          sat_q [QW];

  logic [DW-1:0] rem_d [QW];
  logic [QW-1:0] quo_d [QW];
  logic [DW-1:0] rin   [QW];
  logic [QW-1:0] qin   [QW];
  logic [QW-1:0] lin   [QW];
  logic [DW-1:0] dn    [QW];
  logic [DW:0]   sh    [QW];
  logic [DW:0]   sub   [QW];

  // Saturate when the quotient would not fit
  always_comb begin
    hi     = num_i[NW-1:QW];
    hi_ext = CW'(hi);
    sat_d  = (hi_ext >= CW'(den_i));
  end

  // One compare and subtract per stage
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      rin[k] = (k == 0) ? hi_ext[DW-1:0] : rem_q[(k == 0) ? 0 : k-1];
      qin[k] = (k == 0) ? '0 : quo_q[(k == 0) ? 0 : k-1];
      lin[k] = (k == 0) ? num_i[QW-1:0] : lo_q[(k == 0) ? 0 : k-1];
      dn[k]  = (k == 0) ? den_i : den_q[(k == 0) ? 0 : k-1];
      sh[k]  = {rin[k], lin[k][QW-1-k]};
      sub[k] = sh[k] - {1'b0, dn[k]};
      if (sh[k] >= {1'b0, dn[k]}) begin
        rem_d[k] = sub[k][DW-1:0];
        quo_d[k] = {qin[k][QW-2:0], 1'b1};
      end else begin
        rem_d[k] = sh[k][DW-1:0];
        quo_d[k] = {qin[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        lo_q[k]  <= lin[k];
        den_q[k] <= dn[k];
        sat_q[k] <= (k == 0) ? sat_d : sat_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign quo_o = sat_q[QW-1] ? '1 : quo_q[QW-1];

endmodule

// ===== hw/rtl/wsc_back.sv =====
// Back end: sinc and window pipelines, product, rounding and output register.
`timescale 1ns / 1ps
module wsc_back import wsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     head_valid_i,
  input  wsc_item_t                head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [COEF_W-1:0] out_coefficient_o,
  output logic                     out_in_range_o
);

  typedef struct packed {
    logic               in_range;
    logic               neg;
    logic               xzero;
    logic               centre;
    logic [ALPHA_W-1:0] alpha;
  } wsc_side_t;

  logic en;
  logic out_valid_q;

  // Freeze the whole pipeline while the result beat is held
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && head_valid_i;

  // Side information travels alongside the arithmetic
  logic      vld_q [1:MAG_AT];
  wsc_side_t sb_q  [1:MAG_AT];
  wsc_side_t sb_head;

  assign sb_head = '{in_range: head_i.in_range, neg: head_i.neg, xzero: head_i.xzero,
                     centre: head_i.centre, alpha: head_i.alpha};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= MAG_AT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[1] <= head_valid_i;
      for (int k = 2; k <= MAG_AT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[1] <= sb_head;
      for (int k = 2; k <= MAG_AT; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // Sinc denominator: pi * |x|, held until the sine is ready
  logic [53:0]          den_mul;
  logic [DEN_A_W-1:0]   den_q [1:SIN_LAT];

  assign den_mul = 54'(PI_Q29) * 54'(head_i.ax);

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q[1] <= den_mul[53:25];
      for (int k = 2; k <= SIN_LAT; k++) begin
        den_q[k] <= den_q[k-1];
      end
    end
  end

  // Sinc numerator and quotient
  logic [Q30_W-1:0] s_a;
  logic [QA_W-1:0]  mag_raw;

  wsc_sin u_sin_sinc (
    .clk_i (clk_i),
    .en_i  (en),
    .f_i   ({1'b0, head_i.ax[15:0]}),
    .s_o   (s_a)
  );

  wsc_div #(
    .NW (NUM_A_W),
    .DW (DEN_A_W),
    .QW (QA_W)
  ) u_div_sinc (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({s_a, 20'b0}),
    .den_i (den_q[SIN_LAT]),
    .quo_o (mag_raw)
  );

  // Window phase n / (N - 1), rounded half up
  logic [NUM_B_W-1:0] num_b;
  logic [QB_W-1:0]    u_ph;
  logic [Q30_W-1:0]   s_b;

  assign num_b = {head_i.nn, 17'b0} + NUM_B_W'(head_i.d);

  wsc_div #(
    .NW (NUM_B_W),
    .DW (DEN_B_W),
    .QW (QB_W)
  ) u_div_win (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_b),
    .den_i ({head_i.d, 1'b0}),
    .quo_o (u_ph)
  );

  wsc_sin u_sin_win (
    .clk_i (clk_i),
    .en_i  (en),
    .f_i   (u_ph),
    .s_o   (s_b)
  );

  // Square the sine, then lift by the floor
  logic [61:0]      hsq;
  logic [Q30_W-1:0] h_q;
  logic [Q30_W-1:0] a_w;
  logic [Q30_W-1:0] span;
  logic [61:0]      wprod;
  logic [Q30_W-1:0] win_d;
  logic [Q30_W-1:0] win_q [WIN_AT:MAG_AT];

  always_comb begin
    hsq   = 62'(s_b) * 62'(s_b);
    a_w   = {sb_q[H_AT].alpha, 15'b0};
    span  = ONE_Q30 - a_w;
    wprod = 62'(span) * 62'(h_q);
    win_d = a_w + wprod[Q30_W-1+30:30];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q           <= hsq[Q30_W-1+30:30];
      win_q[WIN_AT] <= win_d;
      for (int k = WIN_AT + 1; k <= MAG_AT; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

  // Combine sinc and window
  logic [QA_W-1:0]  magc;
  logic [Q30_W-1:0] winc;
  logic [62:0]      mprod;
  logic [32:0]      m_q;
  logic             m_vld_q;
  logic             m_rng_q, m_neg_q;

  always_comb begin
    if (sb_q[MAG_AT].xzero) begin
      magc = QA_W'(ONE_Q30);
    end else if (mag_raw > (QA_W'(ONE_Q30) << 1)) begin
      magc = QA_W'(ONE_Q30) << 1;
    end else begin
      magc = mag_raw;
    end
    winc  = sb_q[MAG_AT].centre ? ONE_Q30 : win_q[MAG_AT];
    mprod = 63'(magc) * 63'(winc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= vld_q[MAG_AT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q     <= mprod[62:30];
      m_rng_q <= sb_q[MAG_AT].in_range;
      m_neg_q <= sb_q[MAG_AT].neg;
    end
  end

  // Round to Q15, saturate, apply sign
  logic [33:0]              rnd;
  logic [18:0]              q;
  logic [COEF_W-1:0]        qmag;
  logic [COEF_W-1:0]        coef_d;
  logic signed [COEF_W-1:0] coef_q;
  logic                     rng_q;

  always_comb begin
    rnd = {1'b0, m_q} + 34'd16384;
    q   = rnd[33:15];
    if (m_neg_q) begin
      qmag   = (q > 19'd32768) ? 16'h8000 : q[COEF_W-1:0];
      coef_d = 16'h0000 - qmag;
    end else begin
      qmag   = (q > 19'd32767) ? 16'h7FFF : q[COEF_W-1:0];
      coef_d = qmag;
    end
    if (!m_rng_q) begin
      coef_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      coef_q <= coef_d;
      rng_q  <= m_rng_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_coefficient_o = coef_q;
  assign out_in_range_o    = rng_q;

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> out_valid_q)
    else $error("result beat lost while stalled");

  a_zero_is_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[MAG_AT] && sb_q[MAG_AT].xzero |-> !sb_q[MAG_AT].neg)
    else $error("sinc peak classified as negative");

  a_centre_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[MAG_AT] && sb_q[MAG_AT].centre |-> sb_q[MAG_AT].in_range)
    else $error("centre tap classified out of range");

endmodule

// ===== hw/rtl/windowed_sinc_coefficient_top.sv =====
// Top level of the windowed-sinc interpolation coefficient block.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | in        | in_valid_i/stall_o  | in_tap_index_i
//  out     | out       | out_valid_o/stall_i | out_coefficient_o, out_in_range_o
//  cfg     | in        | cfg_valid_i/ready_o | cfg_index_i, cfg_data_i
//
// One tap index per cycle sustained while the output is not stalled; once its beat is
// taken, a result passes through the 6-stage sine and then the 32-stage sinc divider.
// A two-entry queue sits between the classifier and the arithmetic pipeline.
// A stalled output beat freezes the whole pipeline; input keeps being taken
// until the queue is full. Reset is asynchronous; no clearing pass.
`timescale 1ns / 1ps
module windowed_sinc_coefficient_top import wsc_pkg::*; #(
  parameter int unsigned MaxTaps = MAX_TAPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [TAP_W-1:0]         in_tap_index_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [COEF_W-1:0] out_coefficient_o,
  output logic                     out_in_range_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  wsc_item_t item_in, item_head;
  logic      q_full, q_empty, q_push, q_pop;

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  wsc_front #(
    .MaxTaps (MaxTaps)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tap_index_i (in_tap_index_i),
    .item_o      (item_in)
  );

  wsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (item_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (item_head)
  );

  wsc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (!q_empty),
    .head_i            (item_head),
    .pop_o             (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_coefficient_o (out_coefficient_o),
    .out_in_range_o    (out_in_range_o)
  );

endmodule

// ===== verif/wsc_result_checker.sv =====
// Result checker of the windowed-sinc coefficient block: predicts and compares each result.
`timescale 1ns / 1ps
module wsc_result_checker import wsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [TAP_W-1:0]         in_tap_index_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [COEF_W-1:0] out_coefficient_i,
  input  logic                     out_in_range_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       checked_o
);

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    logic                     in_range;
  } coef_beat_t;

  localparam longint unsigned ONE30 = 64'd1073741824;

  coef_beat_t          coef_expected_q[$];
  logic [KSIZE_W-1:0]  size_reg;
  logic [ALPHA_W-1:0]  alpha_reg;
  logic [FRAC_W-1:0]   frac_reg;

  // sin(pi * f), f in Q16, result in Q30
  function automatic longint unsigned sine_pi_q30(longint unsigned f);
    longint unsigned t, t30, t2, p, r;
    if (f > 65536) f = 65536;
    t   = (f <= 32768) ? (f << 1) : ((65536 - f) << 1);
    t30 = t << 14;
    t2  = (t30 * t30) >> 30;
    p   = 64'(SIN_C9);
    p   = 64'(SIN_C7) - ((p * t2) >> 30);
    p   = 64'(SIN_C5) - ((p * t2) >> 30);
    p   = 64'(SIN_C3) - ((p * t2) >> 30);
    p   = 64'(SIN_C1) - ((p * t2) >> 30);
    r   = (p * t30) >> 30;
    if (r > ONE30) r = ONE30;
    return r;
  endfunction

  // Work out the coefficient of one tap under the current settings
  function automatic coef_beat_t tap_coefficient(logic [TAP_W-1:0] tap);
    coef_beat_t      res;
    longint unsigned i, n, alpha, ax, mag, win, m, q, s, den, nn, d, u, h, a;
    longint          x;
    bit              neg;
    i     = tap;
    n     = size_reg;
    alpha = alpha_reg;
    neg   = 0;
    if (n > MAX_TAPS_DEF) n = MAX_TAPS_DEF;
    if (alpha > 32768) alpha = 32768;
    if (i >= n) begin
      res.coef     = '0;
      res.in_range = 1'b0;
      return res;
    end
    // sinc
    x = longint'((i + 1) * 65536) - longint'(n * 32768) - longint'(frac_reg);
    if (x == 0) begin
      mag = ONE30;
    end else begin
      ax  = (x < 0) ? longint'(-x) : x;
      neg = ax[16];
      s   = sine_pi_q30(ax & 64'hFFFF);
      den = (64'(PI_Q29) * ax) >> 25;
      mag = (s << 20) / den;
    end
    // window
    if (n[0] && i == n / 2) begin
      win = ONE30;
    end else begin
      nn  = (i < n / 2) ? i : (n - 1 - i);
      d   = n - 1;
      u   = ((nn << 17) + d) / (d << 1);
      s   = sine_pi_q30(u);
      h   = (s * s) >> 30;
      a   = alpha << 15;
      win = a + (((ONE30 - a) * h) >> 30);
    end
    if (mag > 2 * ONE30) mag = 2 * ONE30;
    if (win > 2 * ONE30) win = 2 * ONE30;
    m = (mag * win) >> 30;
    q = (m + 16384) >> 15;
    if (neg) begin
      if (q > 32768) q = 32768;
      res.coef = COEF_W'(-q);
    end else begin
      if (q > 32767) q = 32767;
      res.coef = COEF_W'(q);
    end
    res.in_range = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors_o++;
  endtask

  assign pending_o = coef_expected_q.size();

  // Track settings, predict accepted taps, compare delivered beats
  always @(posedge clk_i or negedge rst_ni) begin
    coef_beat_t exp_beat;
    if (!rst_ni) begin
      size_reg  <= KSIZE_RST;
      alpha_reg <= '0;
      frac_reg  <= '0;
      coef_expected_q.delete();
      errors_o  = 0;
      checked_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) coef_expected_q.push_back(tap_coefficient(in_tap_index_i));
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (coef_expected_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          exp_beat = coef_expected_q.pop_front();
          if (out_coefficient_i !== exp_beat.coef)
            report_mismatch($sformatf("coefficient %0d, expected %0d",
                                      out_coefficient_i, exp_beat.coef));
          if (out_in_range_i !== exp_beat.in_range)
            report_mismatch($sformatf("in_range %0b, expected %0b",
                                      out_in_range_i, exp_beat.in_range));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_KERNEL_SIZE: size_reg  <= cfg_data_i[KSIZE_W-1:0];
          CFG_HANN_ALPHA:  alpha_reg <= cfg_data_i;
          CFG_FRACTION:    frac_reg  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== verif/windowed_sinc_coefficient_top_test.sv =====
// Stimulus and verdict for the windowed-sinc coefficient block.
`timescale 1ns / 1ps
module windowed_sinc_coefficient_top_test;
  import wsc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 60;

  logic                     clk_i, rst_ni;
  logic                     in_valid_i, in_stall_o;
  logic [TAP_W-1:0]         in_tap_index_i;
  logic                     out_valid_o, out_stall_i;
  logic signed [COEF_W-1:0] out_coefficient_o;
  logic                     out_in_range_o;
  logic                     cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;
  int                       errors, pending, checked;
  int                       tx_idle_pct, rx_idle_pct, hold_cycles, taps_sent;
  logic [KSIZE_W-1:0]       cur_size;

  windowed_sinc_coefficient_top dut (.*);

  wsc_result_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_tap_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_coefficient_i(out_coefficient_o),
    .out_in_range_i(out_in_range_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .errors_o(errors), .pending_o(pending),
    .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random stalls, or a long hold when asked
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic send_tap(logic [TAP_W-1:0] tap);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_tap_index_i <= tap;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    taps_sent++;
  endtask

  // Write one register once every result is home
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_KERNEL_SIZE) cur_size = data[KSIZE_W-1:0];
  endtask

  task automatic set_kernel(logic [CFG_DATA_W-1:0] size, logic [CFG_DATA_W-1:0] alpha,
                            logic [CFG_DATA_W-1:0] frac);
    write_reg(CFG_KERNEL_SIZE, size);
    write_reg(CFG_HANN_ALPHA, alpha);
    write_reg(CFG_FRACTION, frac);
  endtask

  // Mostly taps inside the kernel, some anywhere
  task automatic random_taps(int count);
    int lim;
    lim = (cur_size > MAX_TAPS_DEF) ? MAX_TAPS_DEF : cur_size;
    repeat (count) begin
      if (lim == 0 || $urandom_range(9) < 2) send_tap(TAP_W'($urandom_range(63)));
      else send_tap(TAP_W'($urandom_range(lim - 1)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_tap_index_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = CFG_KERNEL_SIZE; cfg_data_i = '0;
    tx_idle_pct = 30; rx_idle_pct = 78; hold_cycles = 0; taps_sent = 0;
    cur_size = KSIZE_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, centre with zero x, out of range
    send_tap(0); send_tap(3); send_tap(4); send_tap(7); send_tap(8); send_tap(63);
    // Single tap
    set_kernel(1, 0, 0);
    send_tap(0); send_tap(1);
    // Size zero
    write_reg(CFG_KERNEL_SIZE, 0);
    send_tap(0); send_tap(63);
    // Largest kernel, full floor, largest fraction
    set_kernel(64, ALPHA_ONE, 16'hFFFF);
    send_tap(0); send_tap(31); send_tap(32); send_tap(63);
    // Size above the maximum, alpha above one, stray bits above the size field
    set_kernel(16'hFFFF, 16'hFFFF, 16'h8000);
    send_tap(0); send_tap(63);
    // Odd size: centre window of one
    set_kernel(7, 16'h4000, 0);
    send_tap(3); send_tap(0); send_tap(6); send_tap(7);
    // Unknown register is ignored
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_tap(3); send_tap(2);

    // Random phases over several settings
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin tx_idle_pct = 78; rx_idle_pct = 30; end
      if (ph == 6) begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      case (ph)
        0: set_kernel(2, 0, 1);
        1: set_kernel(64, 0, 0);
        8: set_kernel(65, 16'h8001, 16'hFFFF);
        default: set_kernel(CFG_DATA_W'($urandom_range(65535)),
                            CFG_DATA_W'($urandom_range(65535)),
                            CFG_DATA_W'($urandom_range(65535)));
      endcase
      if (ph == 7) hold_cycles = 300;
      random_taps(165);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d tap indices over fifteen kernel settings; %0d coefficients checked.",
             taps_sent, checked);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
